### rtl/sbpe_pkg.sv
// ----------------------------------------------------------------------------
// sbpe_pkg - scanline byte pixel expander shared types
// Transaction and pixel bundle types, line control bit positions, palette constants.
// ----------------------------------------------------------------------------
package sbpe_pkg;

   localparam int PIXEL_W   = 9;
   localparam int NIBBLE_W  = 4;
   localparam int BYTE_W    = 8;

   localparam int CTL_MODE640_BIT = 7;
   localparam int CTL_FILL_BIT    = 5;

   localparam logic [PIXEL_W-1:0] PALETTE_OFFSET = 9'd16;

   localparam logic ACTION_BORDER = 1'b0;
   localparam logic ACTION_VIDEO  = 1'b1;

   typedef logic [PIXEL_W-1:0] pixel_type;

   typedef struct packed {
      logic                action;
      logic [BYTE_W-1:0]   video_byte;
      logic [BYTE_W-1:0]   line_control;
      logic                line_start;
   } req_item_type;

   typedef struct packed {
      pixel_type pixel_a;
      pixel_type pixel_b;
      pixel_type pixel_c;
      pixel_type pixel_d;
   } pixel_set_type;

endpackage

### rtl/sbpe_decode.sv
// ----------------------------------------------------------------------------
// sbpe_decode - byte slot to pixel decoder
// Turns one registered slot into four colour indices and the next fill nibble.
// ----------------------------------------------------------------------------
module sbpe_decode (
   input  sbpe_pkg::req_item_type               item,
   input  logic [sbpe_pkg::NIBBLE_W-1:0]        fill_nibble,
   input  logic [sbpe_pkg::NIBBLE_W-1:0]        border_color,
   output sbpe_pkg::pixel_set_type              pixels,
   output logic [sbpe_pkg::NIBBLE_W-1:0]        fill_next
);

   logic [sbpe_pkg::NIBBLE_W-1:0] fill_eff;
   logic [sbpe_pkg::NIBBLE_W-1:0] hi_nib;
   logic [sbpe_pkg::NIBBLE_W-1:0] lo_nib;
   logic [sbpe_pkg::NIBBLE_W-1:0] hi_col;
   logic [sbpe_pkg::NIBBLE_W-1:0] lo_col;
   logic                          fill_on;
   sbpe_pkg::pixel_type           base;
   sbpe_pkg::pixel_type           border_px;

   always_comb begin
      fill_eff  = item.line_start ? '0 : fill_nibble;
      fill_on   = item.line_control[sbpe_pkg::CTL_FILL_BIT];
      base      = {1'b0, item.line_control[3:0], 4'b0000} + sbpe_pkg::PALETTE_OFFSET;
      border_px = {5'b00000, border_color};
      hi_nib    = item.video_byte[7:4];
      lo_nib    = item.video_byte[3:0];
      // zero nibble under fill repeats the remembered one
      hi_col    = (fill_on && (hi_nib == '0)) ? fill_eff : hi_nib;
      lo_col    = (fill_on && (lo_nib == '0)) ? hi_col : lo_nib;
      fill_next = fill_eff;

      if (item.action == sbpe_pkg::ACTION_BORDER) begin
         pixels.pixel_a = border_px;
         pixels.pixel_b = border_px;
         pixels.pixel_c = border_px;
         pixels.pixel_d = border_px;
      end else if (item.line_control[sbpe_pkg::CTL_MODE640_BIT]) begin
         pixels.pixel_a = base + {7'd0, item.video_byte[7:6]};
         pixels.pixel_b = base + 9'd4  + {7'd0, item.video_byte[5:4]};
         pixels.pixel_c = base + 9'd8  + {7'd0, item.video_byte[3:2]};
         pixels.pixel_d = base + 9'd12 + {7'd0, item.video_byte[1:0]};
      end else begin
         pixels.pixel_a = base + {5'd0, hi_col};
         pixels.pixel_b = pixels.pixel_a;
         pixels.pixel_c = base + {5'd0, lo_col};
         pixels.pixel_d = pixels.pixel_c;
         fill_next      = lo_col;
      end
   end

endmodule

### rtl/scanline_byte_pixel_expander_top.sv
// ----------------------------------------------------------------------------
// scanline_byte_pixel_expander_top - byte slot to four pixel expander
// Input register, decoder and result register with fill nibble state.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one slot transaction (border or video byte with its line
//   control byte and line start flag) under req_valid/req_ready.
//   rsp_* returns four colour indices per slot under rsp_valid/rsp_ready.
//   csr_wr_en/csr_wr_data set the border colour; write only while idle.
// Path: an accepted slot enters the input register and moves on into the
//   result register, where rsp_valid rises; a stall can hold it in between.
// Throughput: one transaction per cycle while rsp_ready is high; the decoder
//   between the two registers is a single pass of adders and multiplexers.
// The fill nibble is updated as each slot moves into the result register,
//   so slots see it strictly in order.
// Reset: both stages empty, fill nibble and border colour cleared.
// Stall: with rsp_ready low the result holds, the input register keeps one
//   more transaction, and req_ready drops once both stages are full.
// ----------------------------------------------------------------------------
module scanline_byte_pixel_expander_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_action,
   input  logic [sbpe_pkg::BYTE_W-1:0]    req_video_byte,
   input  logic [sbpe_pkg::BYTE_W-1:0]    req_line_control,
   input  logic                           req_line_start,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [sbpe_pkg::PIXEL_W-1:0]   rsp_pixel_a,
   output logic [sbpe_pkg::PIXEL_W-1:0]   rsp_pixel_b,
   output logic [sbpe_pkg::PIXEL_W-1:0]   rsp_pixel_c,
   output logic [sbpe_pkg::PIXEL_W-1:0]   rsp_pixel_d,
   input  logic                           csr_wr_en,
   input  logic [sbpe_pkg::NIBBLE_W-1:0]  csr_wr_data
);

   sbpe_pkg::req_item_type        item_ff;
   sbpe_pkg::req_item_type        item_in;
   logic                          item_valid_ff;
   logic                          item_valid_in;
   sbpe_pkg::pixel_set_type       rsp_ff;
   sbpe_pkg::pixel_set_type       rsp_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [sbpe_pkg::NIBBLE_W-1:0] fill_ff;
   logic [sbpe_pkg::NIBBLE_W-1:0] fill_in;
   logic [sbpe_pkg::NIBBLE_W-1:0] border_ff;
   logic [sbpe_pkg::NIBBLE_W-1:0] border_in;
   sbpe_pkg::pixel_set_type       dec_pixels;
   logic [sbpe_pkg::NIBBLE_W-1:0] dec_fill;
   logic                          advance;
   logic                          req_take;

   sbpe_decode u_decode (
      .item         (item_ff),
      .fill_nibble  (fill_ff),
      .border_color (border_ff),
      .pixels       (dec_pixels),
      .fill_next    (dec_fill)
   );

   always_comb begin
      advance   = !rsp_valid_ff || rsp_ready;
      req_ready = !item_valid_ff || advance;
      req_take  = req_valid && req_ready;

      item_in.action       = req_action;
      item_in.video_byte   = req_video_byte;
      item_in.line_control = req_line_control;
      item_in.line_start   = req_line_start;
      item_valid_in        = req_take || (item_valid_ff && !advance);

      rsp_in       = dec_pixels;
      rsp_valid_in = advance ? item_valid_ff : rsp_valid_ff;
      fill_in      = (advance && item_valid_ff) ? dec_fill : fill_ff;
      border_in    = csr_wr_en ? csr_wr_data : border_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fill_ff       <= '0;
         border_ff     <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         fill_ff       <= fill_in;
         border_ff     <= border_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance && item_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pixel_a = rsp_ff.pixel_a;
   assign rsp_pixel_b = rsp_ff.pixel_b;
   assign rsp_pixel_c = rsp_ff.pixel_c;
   assign rsp_pixel_d = rsp_ff.pixel_d;

endmodule

### rtl/sbpe_checker.sv
// ----------------------------------------------------------------------------
// sbpe_checker - port level checks for the pixel expander
// Watches the top level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module sbpe_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [sbpe_pkg::PIXEL_W-1:0]   rsp_pixel_a,
   input logic [sbpe_pkg::PIXEL_W-1:0]   rsp_pixel_b,
   input logic [sbpe_pkg::PIXEL_W-1:0]   rsp_pixel_c,
   input logic [sbpe_pkg::PIXEL_W-1:0]   rsp_pixel_d
);

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pixel_a) &&
         $stable(rsp_pixel_b) && $stable(rsp_pixel_c) && $stable(rsp_pixel_d)))
      else $error("stalled response changed");

   a_pixel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pixel_a <= 9'd271 && rsp_pixel_b <= 9'd271 &&
         rsp_pixel_c <= 9'd271 && rsp_pixel_d <= 9'd271))
      else $error("pixel index out of range");

   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid) && !$past(reset, 1) && !$past(reset, 2))
         |-> $past(req_valid && req_ready, 2))
      else $error("response without a matching request transaction");

endmodule

bind scanline_byte_pixel_expander_top sbpe_checker u_sbpe_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_pixel_a (rsp_pixel_a),
   .rsp_pixel_b (rsp_pixel_b),
   .rsp_pixel_c (rsp_pixel_c),
   .rsp_pixel_d (rsp_pixel_d)
);

### verif/sbpe_checker.sv
// ----------------------------------------------------------------------------
// sbpe_tb_checker - pixel expander transaction checker
// Watches the slot and pixel channels and the border colour port. Each accepted
// slot is expanded into the four expected colour indices, and each returned
// pixel transaction is compared with the oldest one still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbpe_tb_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            req_action,
   input  logic [sbpe_pkg::BYTE_W-1:0]     req_video_byte,
   input  logic [sbpe_pkg::BYTE_W-1:0]     req_line_control,
   input  logic                            req_line_start,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [sbpe_pkg::PIXEL_W-1:0]    rsp_pixel_a,
   input  logic [sbpe_pkg::PIXEL_W-1:0]    rsp_pixel_b,
   input  logic [sbpe_pkg::PIXEL_W-1:0]    rsp_pixel_c,
   input  logic [sbpe_pkg::PIXEL_W-1:0]    rsp_pixel_d,
   input  logic                            csr_wr_en,
   input  logic [sbpe_pkg::NIBBLE_W-1:0]   csr_wr_data,
   output int                              fail_count,
   output int                              pending_count
);

   logic [sbpe_pkg::NIBBLE_W-1:0] border_nib;
   logic [sbpe_pkg::NIBBLE_W-1:0] fill_nib;
   sbpe_pkg::pixel_set_type       pending_pixels[$];

   task automatic report_fault(input string msg);
      $display("[%0t] sbpe_tb_checker: %s", $realtime, msg);
      fail_count++;
   endtask

   // fill handling: a zero nibble in fill mode reuses the held nibble
   function automatic logic [sbpe_pkg::NIBBLE_W-1:0] fill_select(
      input logic [sbpe_pkg::NIBBLE_W-1:0] nib,
      input logic                          fill);
      if (fill && nib == '0)
         return fill_nib;
      fill_nib = nib;
      return nib;
   endfunction

   function automatic sbpe_pkg::pixel_set_type expand_slot(
      input sbpe_pkg::req_item_type slot);
      sbpe_pkg::pixel_set_type       px;
      sbpe_pkg::pixel_type           base;
      sbpe_pkg::pixel_type           lane[4];
      logic [1:0]                    pair;
      logic [sbpe_pkg::NIBBLE_W-1:0] hi;
      logic [sbpe_pkg::NIBBLE_W-1:0] lo;
      if (slot.line_start)
         fill_nib = '0;
      if (slot.action == sbpe_pkg::ACTION_BORDER) begin
         for (int i = 0; i < 4; i++)
            lane[i] = sbpe_pkg::pixel_type'(border_nib);
      end else begin
         base = sbpe_pkg::pixel_type'({slot.line_control[3:0], 4'b0000})
                + sbpe_pkg::PALETTE_OFFSET;
         if (slot.line_control[sbpe_pkg::CTL_MODE640_BIT]) begin
            for (int i = 0; i < 4; i++) begin
               pair = slot.video_byte[7 - 2*i -: 2];
               lane[i] = base + sbpe_pkg::pixel_type'(4*i) + sbpe_pkg::pixel_type'(pair);
            end
         end else begin
            hi = fill_select(slot.video_byte[7:4],
                             slot.line_control[sbpe_pkg::CTL_FILL_BIT]);
            lo = fill_select(slot.video_byte[3:0],
                             slot.line_control[sbpe_pkg::CTL_FILL_BIT]);
            lane[0] = base + sbpe_pkg::pixel_type'(hi);
            lane[1] = lane[0];
            lane[2] = base + sbpe_pkg::pixel_type'(lo);
            lane[3] = lane[2];
         end
      end
      px.pixel_a = lane[0];
      px.pixel_b = lane[1];
      px.pixel_c = lane[2];
      px.pixel_d = lane[3];
      return px;
   endfunction

   always @(posedge clock) begin
      sbpe_pkg::req_item_type  slot;
      sbpe_pkg::pixel_set_type want;
      if (reset) begin
         border_nib = '0;
         fill_nib   = '0;
         fail_count = 0;
         pending_pixels.delete();
      end else begin
         // result side first: a result in the same cycle belongs to an older slot
         if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               report_fault("pixel transaction with nothing expected");
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_pixel_a !== want.pixel_a)
                  report_fault($sformatf("pixel_a got %0d exp %0d", rsp_pixel_a, want.pixel_a));
               if (rsp_pixel_b !== want.pixel_b)
                  report_fault($sformatf("pixel_b got %0d exp %0d", rsp_pixel_b, want.pixel_b));
               if (rsp_pixel_c !== want.pixel_c)
                  report_fault($sformatf("pixel_c got %0d exp %0d", rsp_pixel_c, want.pixel_c));
               if (rsp_pixel_d !== want.pixel_d)
                  report_fault($sformatf("pixel_d got %0d exp %0d", rsp_pixel_d, want.pixel_d));
            end
         end
         if (req_valid && req_ready) begin
            slot.action       = req_action;
            slot.video_byte   = req_video_byte;
            slot.line_control = req_line_control;
            slot.line_start   = req_line_start;
            pending_pixels.push_back(expand_slot(slot));
         end
         if (csr_wr_en)
            border_nib = csr_wr_data;
      end
      pending_count = pending_pixels.size();
   end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - pixel expander testbench
// Drives border and video slot transactions with random gaps and result
// back-pressure, sets the border colour between phases, and gives the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int BYTE_W   = sbpe_pkg::BYTE_W;
   localparam int NIBBLE_W = sbpe_pkg::NIBBLE_W;
   localparam int PIXEL_W  = sbpe_pkg::PIXEL_W;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic                  req_action       = sbpe_pkg::ACTION_BORDER;
   logic [BYTE_W-1:0]     req_video_byte   = '0;
   logic [BYTE_W-1:0]     req_line_control = '0;
   logic                  req_line_start   = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [PIXEL_W-1:0]    rsp_pixel_a;
   logic [PIXEL_W-1:0]    rsp_pixel_b;
   logic [PIXEL_W-1:0]    rsp_pixel_c;
   logic [PIXEL_W-1:0]    rsp_pixel_d;
   logic                  csr_wr_en        = 1'b0;
   logic [NIBBLE_W-1:0]   csr_wr_data      = '0;
   int                    fail_count;
   int                    pending_count;

   bit                    no_idle    = 1'b0;
   int unsigned           slots_sent = 0;
   int unsigned           sink_run   = 0;

   scanline_byte_pixel_expander_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_video_byte   (req_video_byte),
      .req_line_control (req_line_control),
      .req_line_start   (req_line_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_a      (rsp_pixel_a),
      .rsp_pixel_b      (rsp_pixel_b),
      .rsp_pixel_c      (rsp_pixel_c),
      .rsp_pixel_d      (rsp_pixel_d),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   sbpe_tb_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_video_byte   (req_video_byte),
      .req_line_control (req_line_control),
      .req_line_start   (req_line_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_a      (rsp_pixel_a),
      .rsp_pixel_b      (rsp_pixel_b),
      .rsp_pixel_c      (rsp_pixel_c),
      .rsp_pixel_d      (rsp_pixel_d),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned idle_gap();
      int unsigned r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // result back-pressure: runs of ready high, then stalls mostly short
   always @(negedge clock) begin
      if (sink_run != 0) begin
         sink_run--;
      end else if (no_idle || $urandom_range(0, 3) != 0) begin
         rsp_ready <= 1'b1;
         sink_run = $urandom_range(0, 12);
      end else begin
         rsp_ready <= 1'b0;
         sink_run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end
   end

   task automatic send_slot(input logic act, input logic [BYTE_W-1:0] vb,
                            input logic [BYTE_W-1:0] ctl, input logic start);
      int unsigned gap;
      gap = idle_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_video_byte   <= vb;
      req_line_control <= ctl;
      req_line_start   <= start;
      do @(posedge clock); while (!req_ready);
      slots_sent++;
   endtask

   task automatic drain_and_set_border(input logic [NIBBLE_W-1:0] colour);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= colour;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [NIBBLE_W-1:0] rand_nibble();
      if ($urandom_range(0, 9) < 4)
         return '0;
      return NIBBLE_W'($urandom_range(0, 15));
   endfunction

   task automatic run_lines(input int unsigned count);
      int unsigned           goal;
      int unsigned           len;
      logic [BYTE_W-1:0]     ctl;
      goal = slots_sent + count;
      while (slots_sent < goal) begin
         if ($urandom_range(0, 99) < 85) begin
            ctl = BYTE_W'($urandom_range(0, 255));
            repeat ($urandom_range(0, 2))
               send_slot(sbpe_pkg::ACTION_BORDER, BYTE_W'($urandom), BYTE_W'($urandom), 1'b0);
            len = $urandom_range(1, 24);
            for (int k = 0; k < len; k++)
               send_slot(sbpe_pkg::ACTION_VIDEO, {rand_nibble(), rand_nibble()}, ctl, k == 0);
            repeat ($urandom_range(0, 2))
               send_slot(sbpe_pkg::ACTION_BORDER, BYTE_W'($urandom), BYTE_W'($urandom), 1'b0);
         end else begin
            send_slot(1'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), 1'($urandom));
         end
      end
   endtask

   initial begin
      logic [NIBBLE_W-1:0] colours[6];
      colours = '{4'd0, 4'd15, NIBBLE_W'($urandom), 4'd9, 4'd6, NIBBLE_W'($urandom)};
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, both modes, fill memory and line start cases
      send_slot(sbpe_pkg::ACTION_BORDER, 8'h00, 8'h00, 1'b0);
      send_slot(sbpe_pkg::ACTION_VIDEO,  8'h00, 8'h80, 1'b0);
      send_slot(sbpe_pkg::ACTION_VIDEO,  8'hFF, 8'h8F, 1'b0);
      send_slot(sbpe_pkg::ACTION_VIDEO,  8'h1B, 8'hDF, 1'b0);
      send_slot(sbpe_pkg::ACTION_VIDEO,  8'hE4, 8'h80, 1'b0);
      send_slot(sbpe_pkg::ACTION_VIDEO,  8'h00, 8'h00, 1'b1);
      send_slot(sbpe_pkg::ACTION_VIDEO,  8'hFF, 8'h0F, 1'b0);
      send_slot(sbpe_pkg::ACTION_VIDEO,  8'h3C, 8'h50, 1'b0);
      send_slot(sbpe_pkg::ACTION_VIDEO,  8'h70, 8'h20, 1'b0);
      send_slot(sbpe_pkg::ACTION_VIDEO,  8'h00, 8'h2F, 1'b0);
      send_slot(sbpe_pkg::ACTION_VIDEO,  8'h05, 8'h20, 1'b0);
      send_slot(sbpe_pkg::ACTION_VIDEO,  8'h00, 8'h20, 1'b0);
      send_slot(sbpe_pkg::ACTION_VIDEO,  8'hAA, 8'h80, 1'b0);
      send_slot(sbpe_pkg::ACTION_VIDEO,  8'h00, 8'h20, 1'b0);
      send_slot(sbpe_pkg::ACTION_VIDEO,  8'h00, 8'h20, 1'b1);
      send_slot(sbpe_pkg::ACTION_VIDEO,  8'h09, 8'h3A, 1'b0);
      send_slot(sbpe_pkg::ACTION_VIDEO,  8'h60, 8'h20, 1'b0);
      send_slot(sbpe_pkg::ACTION_BORDER, 8'hFF, 8'hFF, 1'b1);
      send_slot(sbpe_pkg::ACTION_VIDEO,  8'h00, 8'h20, 1'b0);
      send_slot(sbpe_pkg::ACTION_VIDEO,  8'h80, 8'h00, 1'b0);
      send_slot(sbpe_pkg::ACTION_VIDEO,  8'h00, 8'h20, 1'b0);
      drain_and_set_border(4'd15);
      send_slot(sbpe_pkg::ACTION_BORDER, 8'h5A, 8'hA5, 1'b0);
      send_slot(sbpe_pkg::ACTION_BORDER, 8'hFF, 8'hFF, 1'b1);

      for (int p = 0; p < 6; p++) begin
         drain_and_set_border(colours[p]);
         no_idle = (p == 2);
         run_lines(130);
      end
      no_idle = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("** scanline_byte_pixel_expander_top: PASSED **");
      else
         $display("** scanline_byte_pixel_expander_top: FAILED **");
      $finish;
   end

   initial begin
      #6_000_000;
      $display("** scanline_byte_pixel_expander_top: FAILED **");
      $finish;
   end

endmodule
